>>> rtl/file_url_percent_decoder_defines.svh
// Assertion macros for the file URL percent decoder.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef FILE_URL_PERCENT_DECODER_DEFINES_SVH
`define FILE_URL_PERCENT_DECODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FUD_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("file url decoder: invariant violated");
`define FUD_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("file url decoder: sequence violated");
`else
`define FUD_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define FUD_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

>>> rtl/fud_pkg.sv
// Package for the file URL percent decoder: beat types, parse mode enum,
// character constants and the scheme and hex helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fud_pkg;

    localparam int CHAR_W      = 21;
    localparam int LEN_W       = 16;
    localparam int CAP_W       = 16;
    localparam int PREFIX_LEN  = 7;
    localparam int MAX_RESULTS = 8;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [CAP_W-1:0]  t_cap;

    localparam t_char CH_PERCENT = 21'h25;
    localparam t_char CH_SLASH   = 21'h2F;
    localparam t_len  LEN_MAX    = 16'hFFFF;
    localparam t_cap  CAP_RESET  = 16'd260;

    typedef struct packed {
        t_char url_char;
        logic  no_char;
        logic  is_last;
    } t_in_beat;

    typedef struct packed {
        t_char path_char;
        logic  char_valid;
        logic  end_of_path;
        logic  status;
        t_len  path_length;
    } t_out_beat;

    typedef enum logic [1:0] {
        MODE_PREFIX,
        MODE_PASS,
        MODE_HOST,
        MODE_DECODE
    } t_mode;

    // "file://"
    function automatic t_char scheme_char(input logic [2:0] idx);
        t_char c;
        case (idx)
            3'd0: c = 21'h66;
            3'd1: c = 21'h69;
            3'd2: c = 21'h6C;
            3'd3: c = 21'h65;
            3'd4: c = 21'h3A;
            3'd5: c = 21'h2F;
            3'd6: c = 21'h2F;
            default: c = '0;
        endcase
        return c;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input t_char c);
        logic [4:0] r;
        r = '0;
        if (c >= 21'h30 && c <= 21'h39) begin
            r = {1'b1, 4'(c - 21'h30)};
        end else if (c >= 21'h61 && c <= 21'h66) begin
            r = {1'b1, 4'(c - 21'h57)};
        end else if (c >= 21'h41 && c <= 21'h46) begin
            r = {1'b1, 4'(c - 21'h37)};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/file_url_percent_decoder.sv
// File URL to path decoder, top level: scheme and host strip, percent decoding.
// Depends on fud_pkg and file_url_percent_decoder_defines.svh.
//
// Accepts one URL character per cycle while o_in_stall is low. Each input
// beat is registered, then decoded in one pass into a burst of zero to eight
// result beats held in a small output buffer; the buffer drains one beat per
// cycle unless the receiver stalls. Ordinary characters stream at one per
// cycle when the receiver does not stall, and a prefix mismatch or the end of
// a URL yields up to eight result beats. The burst buffer drain sets the
// rate; the input is stalled while result beats of the previous item are
// still waiting, whether a burst is leaving or the receiver stalls, unless
// the last of them leaves in that cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "file_url_percent_decoder_defines.svh"
module file_url_percent_decoder #(
    parameter int COUNT_BITS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire fud_pkg::t_cap   i_cfg_data,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire fud_pkg::t_in_beat i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output fud_pkg::t_out_beat   o_out_data
);

    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS + 1 : 17;

    fud_pkg::t_cap      r_cap;
    fud_pkg::t_in_beat  r_in;
    logic               r_in_valid;
    fud_pkg::t_mode     r_mode, n_mode;
    logic [2:0]         r_pm, n_pm;
    logic               r_pend, n_pend;
    logic               r_hv, n_hv;
    fud_pkg::t_char     r_held, n_held;
    logic [COUNT_BITS-1:0] r_count, n_count;
    fud_pkg::t_out_beat r_buf [fud_pkg::MAX_RESULTS];
    logic [3:0]         r_idx, r_cnt;

    fud_pkg::t_char     w_ch [fud_pkg::MAX_RESULTS];
    logic [2:0]         w_nch;
    fud_pkg::t_out_beat w_buf [fud_pkg::MAX_RESULTS];
    logic [3:0]         w_total;
    logic               w_match, w_take, w_free, w_advance;
    logic [4:0]         w_hx_hi, w_hx_lo;
    logic [COUNT_BITS:0]   w_sum;
    logic [COUNT_BITS-1:0] w_cnt_new;
    logic [CMP_W-1:0]      w_cnt_ext;
    fud_pkg::t_out_beat w_close;

    assign o_cfg_ready = 1'b1;

    // handshake
    assign w_take      = o_out_valid && !i_out_stall;
    assign w_free      = (r_idx == r_cnt) || (w_take && (r_idx + 4'd1 == r_cnt));
    assign w_advance   = r_in_valid && w_free;
    assign o_in_stall  = r_in_valid && !w_advance;
    assign o_out_valid = (r_idx != r_cnt);
    assign o_out_data  = r_buf[r_idx[2:0]];

    assign w_match = (r_in.url_char == fud_pkg::scheme_char(r_pm));
    assign w_hx_hi = fud_pkg::hex_val(r_held);
    assign w_hx_lo = fud_pkg::hex_val(r_in.url_char);

    // next parse mode
    always_comb begin
        n_mode = r_mode;
        n_pm   = r_pm;
        if (!r_in.no_char) begin
            case (r_mode)
                fud_pkg::MODE_PREFIX: begin
                    if (w_match) begin
                        n_pm = r_pm + 3'd1;
                        if (r_pm == 3'(fud_pkg::PREFIX_LEN - 1)) begin
                            n_mode = fud_pkg::MODE_HOST;
                        end
                    end else begin
                        n_mode = fud_pkg::MODE_PASS;
                    end
                end
                fud_pkg::MODE_HOST: begin
                    if (r_in.url_char == fud_pkg::CH_SLASH) begin
                        n_mode = fud_pkg::MODE_DECODE;
                    end
                end
                default: ;
            endcase
        end
    end

    // characters produced by this beat, plus escape state
    always_comb begin
        logic [2:0] k;
        k      = '0;
        n_pend = r_pend;
        n_hv   = r_hv;
        n_held = r_held;
        for (int i = 0; i < fud_pkg::MAX_RESULTS; i++) begin
            w_ch[i] = '0;
        end
        case (r_mode)
            fud_pkg::MODE_PREFIX: begin
                for (int i = 0; i < fud_pkg::PREFIX_LEN; i++) begin
                    w_ch[i] = (3'(i) < r_pm) ? fud_pkg::scheme_char(3'(i)) : r_in.url_char;
                end
                if (r_in.no_char) begin
                    if (r_in.is_last) begin
                        k = r_pm;
                    end
                end else if (!w_match) begin
                    k = r_pm + 3'd1;
                end else if (r_in.is_last && r_pm != 3'(fud_pkg::PREFIX_LEN - 1)) begin
                    k = r_pm + 3'd1;
                end
            end
            fud_pkg::MODE_PASS: begin
                if (!r_in.no_char) begin
                    w_ch[0] = r_in.url_char;
                    k = 3'd1;
                end
            end
            fud_pkg::MODE_HOST: begin
                if (!r_in.no_char && r_in.url_char == fud_pkg::CH_SLASH) begin
                    w_ch[0] = r_in.url_char;
                    k = 3'd1;
                end
            end
            fud_pkg::MODE_DECODE: begin
                if (!r_in.no_char) begin
                    if (!r_pend) begin
                        if (r_in.url_char == fud_pkg::CH_PERCENT) begin
                            n_pend = 1'b1;
                            n_hv   = 1'b0;
                        end else begin
                            w_ch[k] = r_in.url_char;
                            k = k + 3'd1;
                        end
                    end else if (!r_hv) begin
                        n_held = r_in.url_char;
                        n_hv   = 1'b1;
                    end else begin
                        n_pend = 1'b0;
                        n_hv   = 1'b0;
                        n_held = '0;
                        if (w_hx_hi[4] && w_hx_lo[4]) begin
                            w_ch[k] = fud_pkg::t_char'({w_hx_hi[3:0], w_hx_lo[3:0]});
                            k = k + 3'd1;
                        end else begin
                            w_ch[k] = fud_pkg::CH_PERCENT;
                            k = k + 3'd1;
                            if (r_held == fud_pkg::CH_PERCENT) begin
                                n_pend = 1'b1;
                                n_held = r_in.url_char;
                                n_hv   = 1'b1;
                            end else begin
                                w_ch[k] = r_held;
                                k = k + 3'd1;
                                if (r_in.url_char == fud_pkg::CH_PERCENT) begin
                                    n_pend = 1'b1;
                                end else begin
                                    w_ch[k] = r_in.url_char;
                                    k = k + 3'd1;
                                end
                            end
                        end
                    end
                end
                // escape cut short at end of URL
                if (r_in.is_last && n_pend) begin
                    w_ch[k] = fud_pkg::CH_PERCENT;
                    k = k + 3'd1;
                    if (n_hv) begin
                        w_ch[k] = n_held;
                        k = k + 3'd1;
                    end
                end
            end
            default: ;
        endcase
        w_nch = k;
    end

    // length, status and burst assembly
    always_comb begin
        w_sum     = {1'b0, r_count} + (COUNT_BITS + 1)'(w_nch);
        w_cnt_new = w_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : w_sum[COUNT_BITS-1:0];
        w_cnt_ext = CMP_W'(w_cnt_new);
        w_close.path_char   = '0;
        w_close.char_valid  = 1'b0;
        w_close.end_of_path = 1'b1;
        w_close.status      = (w_cnt_ext + CMP_W'(1)) > CMP_W'(r_cap);
        w_close.path_length = (w_cnt_ext > CMP_W'(fud_pkg::LEN_MAX)) ? fud_pkg::LEN_MAX
                                                                    : w_cnt_ext[15:0];
        for (int i = 0; i < fud_pkg::MAX_RESULTS; i++) begin
            if (4'(i) < {1'b0, w_nch}) begin
                w_buf[i].path_char   = w_ch[i];
                w_buf[i].char_valid  = 1'b1;
                w_buf[i].end_of_path = 1'b0;
                w_buf[i].status      = 1'b0;
                w_buf[i].path_length = '0;
            end else begin
                w_buf[i] = w_close;
            end
        end
        w_total = {1'b0, w_nch} + {3'b000, r_in.is_last};
        n_count = r_in.is_last ? '0 : w_cnt_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap      <= fud_pkg::CAP_RESET;
            r_in_valid <= 1'b0;
            r_mode     <= fud_pkg::MODE_PREFIX;
            r_pm       <= '0;
            r_pend     <= 1'b0;
            r_hv       <= 1'b0;
            r_held     <= '0;
            r_count    <= '0;
            r_idx      <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_idx <= '0;
                r_cnt <= w_total;
                if (r_in.is_last) begin
                    r_mode <= fud_pkg::MODE_PREFIX;
                    r_pm   <= '0;
                    r_pend <= 1'b0;
                    r_hv   <= 1'b0;
                    r_held <= '0;
                end else begin
                    r_mode <= n_mode;
                    r_pm   <= n_pm;
                    r_pend <= n_pend;
                    r_hv   <= n_hv;
                    r_held <= n_held;
                end
                r_count <= n_count;
            end else if (w_take) begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (w_advance) begin
            for (int i = 0; i < fud_pkg::MAX_RESULTS; i++) begin
                r_buf[i] <= w_buf[i];
            end
        end
    end

    `FUD_ASSERT_IMPL(a_idx_bound, i_clk, i_rst_n, 1'b1, r_idx <= r_cnt)
    `FUD_ASSERT_IMPL(a_prefix_bound, i_clk, i_rst_n, r_mode == fud_pkg::MODE_PREFIX, r_pm < 3'(fud_pkg::PREFIX_LEN))
    `FUD_ASSERT_IMPL(a_held_in_escape, i_clk, i_rst_n, r_hv, r_pend)
    `FUD_ASSERT_IMPL(a_escape_in_decode, i_clk, i_rst_n, r_pend, r_mode == fud_pkg::MODE_DECODE)
    `FUD_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, w_advance && r_in.is_last, r_mode == fud_pkg::MODE_PREFIX && r_pm == 3'd0 && r_count == '0)

endmodule
`default_nettype wire
